// ===== design/fxda_pkg.sv =====
// Shared types, character codes and elaboration-time helpers for the
// fixed-point to decimal text formatter. No dependencies.

package fxda_pkg;

    // Width of the signed fixed-point input value.
    localparam int VALUE_W = 48;
    // Width of one ASCII character.
    localparam int CHAR_W = 7;

    // Defaults of the top-level parameters.
    localparam int FRAC_BITS_DEF   = 16;
    localparam int FRAC_DIGITS_DEF = 4;
    localparam int WHOLE_LIMIT_DEF = 999999999;

    // Length of the overflow marker text.
    localparam int OVF_LEN = 10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FMUL,
        ST_ROUND,
        ST_RANGE,
        ST_LOAD,
        ST_DABBLE,
        ST_FIND,
        ST_SIGN,
        ST_WHOLE,
        ST_DOT,
        ST_FRAC,
        ST_OVF
    } state_t;

    // Ten to the power k, evaluated at elaboration.
    function automatic longint unsigned pow10(input int k);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < k; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // Number of decimal digits needed to write v (at least one).
    function automatic int num_digits(input longint unsigned v);
        int n;
        longint unsigned t;
        n = 1;
        t = v / 10;
        while (t != 0) begin
            n = n + 1;
            t = t / 10;
        end
        return n;
    endfunction

    // Characters of the overflow marker "<overflow>".
    function automatic logic [CHAR_W-1:0] ovf_char(input logic [3:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            4'd0:    c = 7'h3C;
            4'd1:    c = 7'h6F;
            4'd2:    c = 7'h76;
            4'd3:    c = 7'h65;
            4'd4:    c = 7'h72;
            4'd5:    c = 7'h66;
            4'd6:    c = 7'h6C;
            4'd7:    c = 7'h6F;
            4'd8:    c = 7'h77;
            4'd9:    c = 7'h3E;
            default: c = 7'h3F;
        endcase
        return c;
    endfunction

endpackage

// ===== design/fixed_to_decimal_ascii_core.sv =====
// Fixed-point to decimal ASCII text formatter, top level.
// Depends on fxda_pkg for character codes, the state type and helpers.
//
// Usage:
// The input channel (s_valid, s_ready, s_value) takes one request: a signed
// fixed-point number with FRAC_BITS fraction bits. The result channel
// (m_valid, m_ready, m_text_char, m_last, m_overflow) returns its decimal
// text one ASCII character per transfer, most significant first: an optional
// '-', the whole digits without leading zeros, and, when the rounded fraction
// is nonzero, a '.' and up to FRAC_DIGITS fraction digits without trailing
// zeros. m_last marks the final character. A whole part above WHOLE_LIMIT
// yields the ten characters "<overflow>" with m_overflow high and no sign.
// Timing: one request is worked on at a time and s_ready is low meanwhile.
// After acceptance, the setup states FMUL, ROUND, RANGE and LOAD run with one
// shared multiplier, then binary to BCD conversion shifts two bits per cycle,
// the FIND state finds the digit span, the SIGN state handles the sign, and
// then one character leaves per cycle while the receiver does not stall. No
// new request is taken before the final character of the previous one is in
// the output register. A stalled receiver simply holds the sequencer in its
// current character state; the output register keeps the character.
// Reset (aresetn low, synchronous) returns to idle and drops m_valid.

module fixed_to_decimal_ascii_core #(
    parameter int FRAC_BITS   = fxda_pkg::FRAC_BITS_DEF,
    parameter int FRAC_DIGITS = fxda_pkg::FRAC_DIGITS_DEF,
    parameter int WHOLE_LIMIT = fxda_pkg::WHOLE_LIMIT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [fxda_pkg::VALUE_W-1:0]    s_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic        [fxda_pkg::CHAR_W-1:0]     m_text_char,
    output logic                                   m_last,
    output logic                                   m_overflow
);

    // Derived sizes.
    localparam longint unsigned SCALE = fxda_pkg::pow10(FRAC_DIGITS);
    localparam longint unsigned LIMIT_L = longint'(WHOLE_LIMIT);
    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int WLW     = $clog2(LIMIT_L + 1);
    localparam int N_W     = $clog2((LIMIT_L + 1) * SCALE);
    localparam int NS_W    = N_W + (N_W % 2);
    localparam int DAB_STEPS = NS_W / 2;
    localparam int WD      = fxda_pkg::num_digits(LIMIT_L);
    localparam int ND      = WD + FRAC_DIGITS;
    localparam int BCD_W   = 4 * ND;
    localparam int IDX_W   = $clog2(ND);
    localparam int WHOLE_W = fxda_pkg::VALUE_W - FRAC_BITS;
    localparam int CMP_W   = (WHOLE_W > WLW) ? WHOLE_W : WLW;
    localparam int MA_W    = (FRAC_BITS > WLW) ? FRAC_BITS : WLW;
    localparam int P_W     = MA_W + SCALE_W;
    localparam int CNT_MAX = (DAB_STEPS > fxda_pkg::OVF_LEN) ? DAB_STEPS : fxda_pkg::OVF_LEN;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam int CH_W    = fxda_pkg::CHAR_W;

    // Control registers.
    fxda_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    // Datapath registers.
    logic [WHOLE_W-1:0]   whole_reg, whole_next;
    logic [FRAC_BITS-1:0] fbits_reg, fbits_next;
    logic                 neg_reg, neg_next;
    logic [P_W-1:0]       prod_reg, prod_next;
    logic [SCALE_W-1:0]   frac_reg, frac_next;
    logic [NS_W-1:0]      n_reg, n_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     frac_end_reg, frac_end_next;
    logic                 frac_nz_reg, frac_nz_next;
    logic [CH_W-1:0]      m_text_char_reg, m_text_char_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_overflow_reg, m_overflow_next;

    // Shared combinational pieces.
    logic                        out_free;
    logic [fxda_pkg::VALUE_W-1:0] mag;
    logic [MA_W-1:0]             mul_a;
    logic [P_W-1:0]              mul_p;
    logic [P_W:0]                round_sum;
    logic [P_W:0]                frac_full;
    logic                        round_carry;
    logic                        whole_over;
    logic [IDX_W-1:0]            lead;
    logic [IDX_W-1:0]            frac_end;
    logic [3:0]                  cur_digit;
    logic                        dab_done;
    logic                        whole_end;
    logic                        frac_last;
    logic                        ovf_last;

    // One step of shift-and-add-3 binary to BCD conversion.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
                                                input logic din);
        logic [BCD_W-1:0] t;
        t = b;
        for (int i = 0; i < ND; i++) begin
            if (t[4*i +: 4] >= 4'd5) begin
                t[4*i +: 4] = t[4*i +: 4] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], din};
    endfunction

    assign s_ready     = (state_reg == fxda_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_text_char = m_text_char_reg;
    assign m_last      = m_last_reg;
    assign m_overflow  = m_overflow_reg;

    // The output register can take a new character this cycle.
    assign out_free = !m_valid_reg || m_ready;

    // Magnitude of the input; the most negative value maps to 2^47 without wrap.
    assign mag = s_value[fxda_pkg::VALUE_W-1] ? (fxda_pkg::VALUE_W'(0) - s_value) : s_value;

    // The single multiplier is shared: first the fraction bits, later the
    // whole part, each times ten to the FRAC_DIGITS.
    assign mul_a = (state_reg == fxda_pkg::ST_FMUL) ? MA_W'(fbits_reg) : MA_W'(whole_reg);
    assign mul_p = P_W'(mul_a) * P_W'(SCALE);

    // Round half up, then detect a fraction that rounded up to the full scale.
    assign round_sum   = {1'b0, prod_reg} + ((P_W + 1)'(1) << (FRAC_BITS - 1));
    assign frac_full   = round_sum >> FRAC_BITS;
    assign round_carry = (frac_full >= (P_W + 1)'(SCALE));

    assign whole_over = (CMP_W'(whole_reg) > CMP_W'(LIMIT_L));

    // Highest nonzero whole digit (at least the units digit), and the lowest
    // nonzero fraction digit.
    always_comb begin
        lead     = IDX_W'(FRAC_DIGITS);
        frac_end = '0;
        for (int i = FRAC_DIGITS; i < ND; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                lead = IDX_W'(i);
            end
        end
        for (int i = FRAC_DIGITS - 1; i >= 0; i--) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                frac_end = IDX_W'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[{ptr_reg, 2'b00} +: 4];
    assign dab_done  = (cnt_reg == CNT_W'(DAB_STEPS - 1));
    assign whole_end = (ptr_reg == IDX_W'(FRAC_DIGITS));
    assign frac_last = (ptr_reg == frac_end_reg);
    assign ovf_last  = (cnt_reg == CNT_W'(fxda_pkg::OVF_LEN - 1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fxda_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = fxda_pkg::ST_FMUL;
                end
            end
            fxda_pkg::ST_FMUL:  state_next = fxda_pkg::ST_ROUND;
            fxda_pkg::ST_ROUND: state_next = fxda_pkg::ST_RANGE;
            fxda_pkg::ST_RANGE: begin
                state_next = whole_over ? fxda_pkg::ST_OVF : fxda_pkg::ST_LOAD;
            end
            fxda_pkg::ST_LOAD:  state_next = fxda_pkg::ST_DABBLE;
            fxda_pkg::ST_DABBLE: begin
                if (dab_done) begin
                    state_next = fxda_pkg::ST_FIND;
                end
            end
            fxda_pkg::ST_FIND:  state_next = fxda_pkg::ST_SIGN;
            fxda_pkg::ST_SIGN: begin
                if (!neg_reg || out_free) begin
                    state_next = fxda_pkg::ST_WHOLE;
                end
            end
            fxda_pkg::ST_WHOLE: begin
                if (out_free && whole_end) begin
                    state_next = frac_nz_reg ? fxda_pkg::ST_DOT : fxda_pkg::ST_IDLE;
                end
            end
            fxda_pkg::ST_DOT: begin
                if (out_free) begin
                    state_next = fxda_pkg::ST_FRAC;
                end
            end
            fxda_pkg::ST_FRAC: begin
                if (out_free && frac_last) begin
                    state_next = fxda_pkg::ST_IDLE;
                end
            end
            fxda_pkg::ST_OVF: begin
                if (out_free && ovf_last) begin
                    state_next = fxda_pkg::ST_IDLE;
                end
            end
            default: state_next = fxda_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        whole_next       = whole_reg;
        fbits_next       = fbits_reg;
        neg_next         = neg_reg;
        prod_next        = prod_reg;
        frac_next        = frac_reg;
        n_next           = n_reg;
        bcd_next         = bcd_reg;
        cnt_next         = cnt_reg;
        ptr_next         = ptr_reg;
        frac_end_next    = frac_end_reg;
        frac_nz_next     = frac_nz_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_text_char_next = m_text_char_reg;
        m_last_next      = m_last_reg;
        m_overflow_next  = m_overflow_reg;
        unique case (state_reg)
            fxda_pkg::ST_IDLE: begin
                if (s_valid) begin
                    neg_next   = s_value[fxda_pkg::VALUE_W-1];
                    whole_next = mag[fxda_pkg::VALUE_W-1:FRAC_BITS];
                    fbits_next = mag[FRAC_BITS-1:0];
                end
            end
            fxda_pkg::ST_FMUL: begin
                prod_next = mul_p;
            end
            fxda_pkg::ST_ROUND: begin
                frac_next  = round_carry ? '0 : SCALE_W'(frac_full);
                whole_next = whole_reg + WHOLE_W'(round_carry);
            end
            fxda_pkg::ST_RANGE: begin
                prod_next = mul_p;
                cnt_next  = '0;
            end
            fxda_pkg::ST_LOAD: begin
                n_next   = NS_W'(prod_reg) + NS_W'(frac_reg);
                bcd_next = '0;
                cnt_next = '0;
            end
            fxda_pkg::ST_DABBLE: begin
                bcd_next = dabble(dabble(bcd_reg, n_reg[NS_W-1]), n_reg[NS_W-2]);
                n_next   = n_reg << 2;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            fxda_pkg::ST_FIND: begin
                ptr_next      = lead;
                frac_end_next = frac_end;
                frac_nz_next  = (frac_reg != '0);
            end
            fxda_pkg::ST_SIGN: begin
                if (neg_reg && out_free) begin
                    m_valid_next     = 1'b1;
                    m_text_char_next = fxda_pkg::CHAR_MINUS;
                    m_last_next      = 1'b0;
                    m_overflow_next  = 1'b0;
                end
            end
            fxda_pkg::ST_WHOLE: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_text_char_next = fxda_pkg::CHAR_ZERO + CH_W'(cur_digit);
                    m_last_next      = whole_end && !frac_nz_reg;
                    m_overflow_next  = 1'b0;
                    ptr_next         = ptr_reg - IDX_W'(1);
                end
            end
            fxda_pkg::ST_DOT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_text_char_next = fxda_pkg::CHAR_DOT;
                    m_last_next      = 1'b0;
                    m_overflow_next  = 1'b0;
                    ptr_next         = IDX_W'(FRAC_DIGITS - 1);
                end
            end
            fxda_pkg::ST_FRAC: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_text_char_next = fxda_pkg::CHAR_ZERO + CH_W'(cur_digit);
                    m_last_next      = frac_last;
                    m_overflow_next  = 1'b0;
                    ptr_next         = ptr_reg - IDX_W'(1);
                end
            end
            fxda_pkg::ST_OVF: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_text_char_next = fxda_pkg::ovf_char(4'(cnt_reg));
                    m_last_next      = ovf_last;
                    m_overflow_next  = 1'b1;
                    cnt_next         = cnt_reg + CNT_W'(1);
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fxda_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers; every one is written before it is used.
    always_ff @(posedge aclk) begin
        whole_reg       <= whole_next;
        fbits_reg       <= fbits_next;
        neg_reg         <= neg_next;
        prod_reg        <= prod_next;
        frac_reg        <= frac_next;
        n_reg           <= n_next;
        bcd_reg         <= bcd_next;
        cnt_reg         <= cnt_next;
        ptr_reg         <= ptr_next;
        frac_end_reg    <= frac_end_next;
        frac_nz_reg     <= frac_nz_next;
        m_text_char_reg <= m_text_char_next;
        m_last_reg      <= m_last_next;
        m_overflow_reg  <= m_overflow_next;
    end

    // The conversion counter never runs past the last step.
    a_dabble_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fxda_pkg::ST_DABBLE) |-> (cnt_reg < CNT_W'(DAB_STEPS)))
        else $error("BCD conversion ran past its step count");

    // Whole digits are read only from the whole part of the BCD register.
    a_whole_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fxda_pkg::ST_WHOLE) |->
            (ptr_reg >= IDX_W'(FRAC_DIGITS) && ptr_reg <= IDX_W'(ND - 1)))
        else $error("whole digit pointer out of range");

    // Normal text holds only a sign, a point or decimal digits.
    a_text_chars: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_overflow) |->
            (m_text_char == fxda_pkg::CHAR_MINUS || m_text_char == fxda_pkg::CHAR_DOT ||
             (m_text_char >= fxda_pkg::CHAR_ZERO && m_text_char <= fxda_pkg::CHAR_NINE)))
        else $error("unexpected character in number text");

    // Returning to idle always coincides with the final character of the text.
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg != fxda_pkg::ST_IDLE) ##1 (state_reg == fxda_pkg::ST_IDLE)) |->
            (m_valid && m_last))
        else $error("sequencer went idle without a last character");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for fixed_to_decimal_ascii_core.
// Depends on fxda_pkg and the core. It predicts the decimal text of every
// accepted request and checks each returned character against it.

module tb_top;

    // Sizes and formatting parameters the core is built with.
    localparam int VALUE_W = fxda_pkg::VALUE_W;
    localparam int CHAR_W = fxda_pkg::CHAR_W;
    localparam int FRAC_BITS = fxda_pkg::FRAC_BITS_DEF;
    localparam int FRAC_DIGITS = fxda_pkg::FRAC_DIGITS_DEF;
    localparam longint unsigned FRAC_SCALE = fxda_pkg::pow10(FRAC_DIGITS);
    localparam longint unsigned WHOLE_LIMIT = fxda_pkg::WHOLE_LIMIT_DEF;

    // A request finishes well within the watchdog limit even with heavy stalling,
    // so a stretch that long without any handshake means the core is stuck.
    localparam int WATCHDOG_LIMIT = 1000;
    // Quiet cycles after the last character, to catch stray output.
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_PER_PHASE = 107;
    localparam int NUM_PHASES = 4;

    // One character of formatted text as the result channel carries it.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              ovf;
    } text_char_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [CHAR_W-1:0]         m_text_char;
    logic                      m_last;
    logic                      m_overflow;

    // Values waiting to be offered, and characters still owed by the core.
    logic [VALUE_W-1:0] pending_values[$];
    text_char_t         expected_chars[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    always #6 aclk = ~aclk;

    fixed_to_decimal_ascii_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last),
        .m_overflow  (m_overflow)
    );

    // Works out the text of one value and appends its characters to the
    // expectation queue. The magnitude is formed in 49 bits so that the most
    // negative input does not wrap. Rounding is half up to four fraction
    // digits, and a fraction that rounds up to a full unit carries into the
    // whole part before the range test.
    function automatic void predict_text(input logic [VALUE_W-1:0] raw);
        logic              neg;
        logic [VALUE_W:0]  mag;
        longint unsigned   whole;
        longint unsigned   frac;
        logic [CHAR_W-1:0] text[$];
        logic [CHAR_W-1:0] whole_digits[$];
        int                frac_digits[FRAC_DIGITS];
        int                keep;
        string             marker;
        text_char_t        tc;

        neg = raw[VALUE_W-1];
        mag = neg ? ((49'd1 << VALUE_W) - {1'b0, raw}) : {1'b0, raw};
        whole = 64'(mag >> FRAC_BITS);
        frac = (64'(mag[FRAC_BITS-1:0]) * FRAC_SCALE + (64'd1 << (FRAC_BITS - 1)))
               >> FRAC_BITS;
        if (frac >= FRAC_SCALE) begin
            frac = 0;
            whole = whole + 1;
        end

        // Out of range: the marker text, flagged, with no sign.
        if (whole > WHOLE_LIMIT) begin
            marker = "<overflow>";
            for (int i = 0; i < marker.len(); i++) begin
                tc.ch = CHAR_W'(marker[i]);
                tc.last = (i == marker.len() - 1);
                tc.ovf = 1'b1;
                expected_chars.push_back(tc);
            end
            return;
        end

        // A negative value keeps its sign even when it rounds to zero.
        if (neg) begin
            text.push_back(fxda_pkg::CHAR_MINUS);
        end
        do begin
            whole_digits.push_front(fxda_pkg::CHAR_ZERO + CHAR_W'(whole % 10));
            whole = whole / 10;
        end while (whole != 0);
        foreach (whole_digits[i]) begin
            text.push_back(whole_digits[i]);
        end

        if (frac != 0) begin
            for (int i = FRAC_DIGITS - 1; i >= 0; i--) begin
                frac_digits[i] = int'(frac % 10);
                frac = frac / 10;
            end
            keep = FRAC_DIGITS;
            while (keep > 0 && frac_digits[keep-1] == 0) begin
                keep--;
            end
            text.push_back(fxda_pkg::CHAR_DOT);
            for (int i = 0; i < keep; i++) begin
                text.push_back(fxda_pkg::CHAR_ZERO + CHAR_W'(frac_digits[i]));
            end
        end

        foreach (text[i]) begin
            tc.ch = text[i];
            tc.last = (i == text.size() - 1);
            tc.ovf = 1'b0;
            expected_chars.push_back(tc);
        end
    endfunction

    // Builds a fixed-point value from a whole part and fraction bits and
    // gives it the requested sign.
    function automatic logic [VALUE_W-1:0] fixed_value(input longint unsigned whole,
                                                      input longint unsigned frac_bits,
                                                      input logic neg);
        logic [VALUE_W-1:0] mag;

        mag = VALUE_W'((whole << FRAC_BITS) | frac_bits);
        return neg ? (VALUE_W'(0) - mag) : mag;
    endfunction

    // Random values, weighted toward the interesting regions: short numbers,
    // the full nine-digit range, the edge of the overflow range, fractions
    // that sit on a rounding boundary, plain integers, and raw 48-bit
    // patterns that mostly overflow but toggle every input bit.
    function automatic logic [VALUE_W-1:0] random_value();
        longint unsigned whole;
        longint unsigned frac_bits;
        int              kind;

        kind = int'($urandom_range(9));
        frac_bits = 64'($urandom_range(16'hFFFF));
        whole = 0;
        case (kind)
            0, 1, 2, 3: begin
                whole = 64'($urandom_range(999));
            end
            4, 5: begin
                whole = 64'($urandom_range(999_999_999));
            end
            6: begin
                whole = 64'($urandom_range(1_000_000_005, 999_999_990));
                if ($urandom_range(1) == 1) begin
                    frac_bits = ($urandom_range(1) == 1) ? 64'(16'hFFFF) : 64'(16'h0000);
                end
            end
            7: begin
                whole = 64'($urandom_range(99));
                frac_bits = ($urandom_range(1) == 1) ? 64'($urandom_range(7))
                                                     : 64'(16'hFFFF - $urandom_range(15));
            end
            8: begin
                return {16'($urandom), 32'($urandom)};
            end
            default: begin
                whole = 64'($urandom_range(99_999));
                frac_bits = 0;
            end
        endcase
        return fixed_value(whole, frac_bits, $urandom_range(1) == 1);
    endfunction

    // Waits until every queued request has been taken and every character
    // it owes has come back. Sampled on the falling edge, when all clocked
    // updates of the rising edge have settled.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_values.size() != 0 || s_valid || expected_chars.size() != 0);
    endtask

    // Request driver. A new value goes out once the channel is free: either
    // nothing is offered, or the current offer is taken at this edge. While
    // an offer waits, valid and the value stay put. idle_pct sets how often
    // the sender leaves a free slot empty.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_values.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_value <= pending_values.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: ready is dropped at random for stall_pct percent of
    // the cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor. Each accepted request queues the text it should produce; each
    // accepted character is checked field by field against the oldest
    // expectation. The watchdog counts cycles without any handshake.
    always @(posedge aclk) begin : monitor
        text_char_t want;
        logic       took_request;
        logic       took_char;

        took_request = aresetn && s_valid && s_ready;
        took_char = aresetn && m_valid && m_ready;

        if (took_request) begin
            predict_text(s_value);
        end

        if (took_char) begin
            if (expected_chars.size() == 0) begin
                $error("text_char: no character expected, got %h", m_text_char);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                if (m_text_char !== want.ch) begin
                    $error("text_char: expected %h, got %h", want.ch, m_text_char);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_last);
                    mismatches++;
                end
                if (m_overflow !== want.ovf) begin
                    $error("overflow: expected %b, got %b", want.ovf, m_overflow);
                    mismatches++;
                end
            end
        end

        if (took_request || took_char) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int sender_idle[NUM_PHASES];
        int receiver_stall[NUM_PHASES];

        sender_idle = '{0, 60, 0, 29};
        receiver_stall = '{0, 0, 60, 29};

        // Directed requests, run with no idling on either side.
        pending_values.push_back(fixed_value(0, 0, 1'b0));
        // Below the half-up threshold of the last fraction digit, and above it.
        pending_values.push_back(fixed_value(0, 1, 1'b0));
        pending_values.push_back(fixed_value(0, 3, 1'b0));
        pending_values.push_back(fixed_value(0, 4, 1'b0));
        // Negative values below and above the threshold; the one that rounds to zero keeps the minus sign.
        pending_values.push_back(fixed_value(0, 1, 1'b1));
        pending_values.push_back(fixed_value(0, 4, 1'b1));
        pending_values.push_back(fixed_value(0, 16'h8000, 1'b0));
        pending_values.push_back(fixed_value(1, 16'h4000, 1'b0));
        pending_values.push_back(fixed_value(3, 16'hC000, 1'b1));
        pending_values.push_back(fixed_value(12345, 6554, 1'b0));
        // Fractions that round up to a full unit and carry into the whole.
        pending_values.push_back(fixed_value(0, 16'hFFFF, 1'b0));
        pending_values.push_back(fixed_value(0, 16'hFFFF, 1'b1));
        pending_values.push_back(fixed_value(1, 16'hFFFF, 1'b0));
        pending_values.push_back(fixed_value(65535, 16'hFFFF, 1'b0));
        // Largest whole part that still prints, and the carry that pushes it
        // over the limit.
        pending_values.push_back(fixed_value(WHOLE_LIMIT, 0, 1'b0));
        pending_values.push_back(fixed_value(WHOLE_LIMIT, 0, 1'b1));
        pending_values.push_back(fixed_value(WHOLE_LIMIT, 16'hFFFC, 1'b0));
        pending_values.push_back(fixed_value(WHOLE_LIMIT, 16'hFFFF, 1'b0));
        pending_values.push_back(fixed_value(WHOLE_LIMIT, 16'hFFFF, 1'b1));
        // Overflow on both signs, the marker carries no sign.
        pending_values.push_back(fixed_value(WHOLE_LIMIT + 1, 0, 1'b0));
        pending_values.push_back(fixed_value(WHOLE_LIMIT + 1, 0, 1'b1));
        // Largest positive value and the most negative one.
        pending_values.push_back(48'h7FFF_FFFF_FFFF);
        pending_values.push_back(48'h8000_0000_0000);
        pending_values.push_back(48'h5555_5555_5555);
        pending_values.push_back(48'hAAAA_AAAA_AAAA);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Random requests in phases of different idling. Between phases the
        // sender holds off until the core has returned everything it owes.
        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_pct = sender_idle[p];
            stall_pct = receiver_stall[p];
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                pending_values.push_back(random_value());
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
